// File: rtl/pulse_width_code_encoder_macros.svh
// ----------------------------------------------------------------------------
// pulse width code encoder assertion macros
// shared property forms for the encoder's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_CODE_ENCODER_MACROS_SVH
`define PULSE_WIDTH_CODE_ENCODER_MACROS_SVH

// same-cycle implication, reset masked
`define PWCE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define PWCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pwce_pkg.sv
// ----------------------------------------------------------------------------
// pwce_pkg
// types, widths and timing profile table of the pulse width code encoder
// ----------------------------------------------------------------------------
package pwce_pkg;

  localparam int NumProfiles = 12;
  localparam int TableRows   = 12;
  localparam int MaxBits     = 32;

  localparam int IdxW    = 4;
  localparam int BitsW   = 6;
  localparam int CodeW   = 32;
  localparam int RoomW   = 8;
  localparam int DurW    = 16;
  localparam int PeriodW = 10;
  localparam int FactW   = 8;
  localparam int PosW    = $clog2(CodeW);

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_ROOM  = 2'd2
  } err_code_t;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [FactW-1:0]   sync_hi;
    logic [FactW-1:0]   sync_lo;
    logic [FactW-1:0]   zero_hi;
    logic [FactW-1:0]   zero_lo;
    logic [FactW-1:0]   one_hi;
    logic [FactW-1:0]   one_lo;
    logic               inverted;
  } profile_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [BitsW-1:0] bits;
    logic [CodeW-1:0] code;
    err_code_t        err;
  } job_t;

  typedef struct packed {
    logic [DurW-1:0] first;
    logic [DurW-1:0] second;
    logic            last;
    err_code_t       err;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic profile_t profile_of(input logic [IdxW-1:0] idx);
    profile_t p;
    unique case (idx)
      4'd0:    p = '{10'd350, 8'd1,   8'd31,  8'd1,  8'd3,  8'd3,  8'd1,  1'b0};
      4'd1:    p = '{10'd650, 8'd1,   8'd10,  8'd1,  8'd2,  8'd2,  8'd1,  1'b0};
      4'd2:    p = '{10'd100, 8'd30,  8'd71,  8'd4,  8'd11, 8'd9,  8'd6,  1'b0};
      4'd3:    p = '{10'd380, 8'd1,   8'd6,   8'd1,  8'd3,  8'd3,  8'd1,  1'b0};
      4'd4:    p = '{10'd500, 8'd6,   8'd14,  8'd1,  8'd2,  8'd2,  8'd1,  1'b0};
      4'd5:    p = '{10'd450, 8'd23,  8'd1,   8'd1,  8'd2,  8'd2,  8'd1,  1'b1};
      4'd6:    p = '{10'd150, 8'd2,   8'd62,  8'd1,  8'd6,  8'd6,  8'd1,  1'b0};
      4'd7:    p = '{10'd200, 8'd3,   8'd130, 8'd7,  8'd16, 8'd3,  8'd16, 1'b0};
      4'd8:    p = '{10'd200, 8'd130, 8'd7,   8'd16, 8'd7,  8'd16, 8'd3,  1'b1};
      4'd9:    p = '{10'd365, 8'd18,  8'd1,   8'd3,  8'd1,  8'd1,  8'd3,  1'b1};
      4'd10:   p = '{10'd270, 8'd36,  8'd1,   8'd1,  8'd2,  8'd2,  8'd1,  1'b1};
      4'd11:   p = '{10'd320, 8'd36,  8'd1,   8'd1,  8'd2,  8'd2,  8'd1,  1'b1};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/pwce_front.sv
// ----------------------------------------------------------------------------
// pwce_front
// accepts code requests, checks index and room, queues a classified job
// ----------------------------------------------------------------------------
module pwce_front (
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [pwce_pkg::IdxW-1:0]     in_protocol_index,
  input  logic [pwce_pkg::BitsW-1:0]    in_bit_count,
  input  logic [pwce_pkg::CodeW-1:0]    in_code_value,
  input  logic [pwce_pkg::RoomW-1:0]    in_room,
  input  pwce_pkg::q_status_t           jq_status,
  output logic                          jq_push,
  output pwce_pkg::job_t                jq_din
);
  import pwce_pkg::*;

  logic [BitsW-1:0] bits_sat;
  logic [BitsW+2:0] need;
  logic             idx_bad;
  logic             room_bad;

  always_comb begin
    bits_sat = (in_bit_count > BitsW'(MaxBits)) ? BitsW'(MaxBits) : in_bit_count;
    need     = (BitsW+3)'({bits_sat, 1'b0}) + (BitsW+3)'(2);
    idx_bad  = ((IdxW+1)'(in_protocol_index) >= (IdxW+1)'(NumProfiles)) ||
               ((IdxW+1)'(in_protocol_index) >= (IdxW+1)'(TableRows));
    room_bad = (BitsW+3)'(in_room) < need;

    jq_din.idx  = in_protocol_index;
    jq_din.bits = bits_sat;
    jq_din.code = in_code_value;
    // index check wins over room check
    if (idx_bad) begin
      jq_din.err = ERR_INDEX;
    end else if (room_bad) begin
      jq_din.err = ERR_ROOM;
    end else begin
      jq_din.err = ERR_NONE;
    end
  end

  assign in_full = jq_status.full;
  assign jq_push = in_push && !jq_status.full;

endmodule

// File: rtl/pwce_jobq.sv
// ----------------------------------------------------------------------------
// pwce_jobq
// two-entry job queue between the request front and the symbol back
// ----------------------------------------------------------------------------
module pwce_jobq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pwce_pkg::job_t      din,
  input  logic                pop,
  output pwce_pkg::job_t      dout,
  output pwce_pkg::q_status_t status
);
  import pwce_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);
  assign dout         = ent_r[rp_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule

// File: rtl/pwce_back.sv
// ----------------------------------------------------------------------------
// pwce_back
// job -> sync symbol and one symbol per bit, msb first; error job -> one beat
// ----------------------------------------------------------------------------
module pwce_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pwce_pkg::job_t                jq_dout,
  input  pwce_pkg::q_status_t           jq_status,
  output logic                          jq_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [pwce_pkg::DurW-1:0] out_first_pulse_us,
  output logic signed [pwce_pkg::DurW-1:0] out_second_pulse_us,
  output logic                          out_last_symbol,
  output logic [1:0]                    out_error_code
);
  import pwce_pkg::*;

  `include "pulse_width_code_encoder_macros.svh"

  logic             busy_r, busy_nxt;
  logic             sync_r, sync_nxt;
  logic [BitsW-1:0] rem_r, rem_nxt;
  job_t             job_r;

  result_t          ent_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;

  profile_t             prof;
  logic                 load, emit, take;
  logic [PosW-1:0]      pos;
  logic                 bit_val;
  logic [FactW-1:0]     fac_hi, fac_lo;
  logic [PeriodW+FactW-1:0] prod_hi, prod_lo;
  logic [DurW-1:0]      dur_hi, dur_lo;
  result_t              sym;

  assign prof    = profile_of(job_r.idx);
  assign load    = !busy_r && !jq_status.empty;
  assign jq_pop  = load;
  assign emit    = busy_r && (cnt_r != 2'd2);
  assign take    = out_pop && (cnt_r != 2'd0);
  assign pos     = PosW'(rem_r - BitsW'(1));
  assign bit_val = job_r.code[pos];

  always_comb begin
    if (sync_r) begin
      fac_hi = prof.sync_hi;
      fac_lo = prof.sync_lo;
    end else if (bit_val) begin
      fac_hi = prof.one_hi;
      fac_lo = prof.one_lo;
    end else begin
      fac_hi = prof.zero_hi;
      fac_lo = prof.zero_lo;
    end
    prod_hi = (PeriodW+FactW)'(prof.period) * (PeriodW+FactW)'(fac_hi);
    prod_lo = (PeriodW+FactW)'(prof.period) * (PeriodW+FactW)'(fac_lo);
    dur_hi  = DurW'(prod_hi);
    dur_lo  = DurW'(prod_lo);

    if (job_r.err != ERR_NONE) begin
      sym.first  = '0;
      sym.second = '0;
      sym.last   = 1'b1;
      sym.err    = job_r.err;
    end else begin
      // inverted profiles start low
      sym.first  = prof.inverted ? (DurW'(0) - dur_hi) : dur_hi;
      sym.second = prof.inverted ? dur_lo : (DurW'(0) - dur_lo);
      sym.last   = sync_r ? (job_r.bits == '0) : (rem_r == BitsW'(1));
      sym.err    = ERR_NONE;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    sync_nxt = sync_r;
    rem_nxt  = rem_r;
    if (load) begin
      busy_nxt = 1'b1;
      sync_nxt = 1'b1;
    end else if (emit) begin
      sync_nxt = 1'b0;
      rem_nxt  = sync_r ? job_r.bits : rem_r - BitsW'(1);
      if (sym.last) begin
        busy_nxt = 1'b0;
      end
    end
    cnt_nxt = cnt_r + 2'(emit) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sync_r <= 1'b0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      sync_r <= sync_nxt;
      wp_r   <= emit ? ~wp_r : wp_r;
      rp_r   <= take ? ~rp_r : rp_r;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (load) begin
      job_r <= jq_dout;
    end
    if (emit) begin
      ent_r[wp_r] <= sym;
    end
  end

  assign out_empty           = (cnt_r == 2'd0);
  assign out_first_pulse_us  = ent_r[rp_r].first;
  assign out_second_pulse_us = ent_r[rp_r].second;
  assign out_last_symbol     = ent_r[rp_r].last;
  assign out_error_code      = ent_r[rp_r].err;

  `PWCE_ASSERT_SAME(a_out_cnt_bound, 1'b1, cnt_r != 2'd3, "result queue count overflow")
  `PWCE_ASSERT_SAME(a_bit_pending, busy_r && !sync_r, rem_r != '0,
    "bit symbol with no bits left")
  `PWCE_ASSERT_NEXT(a_last_ends_run, emit && sym.last, !busy_r,
    "sequencer still busy after last symbol")
  `PWCE_ASSERT_SAME(a_err_item_shape, !out_empty && (out_error_code != ERR_NONE),
    out_last_symbol && (out_first_pulse_us == '0) && (out_second_pulse_us == '0),
    "malformed error beat")

endmodule

// File: rtl/pulse_width_code_encoder.sv
// an accepted request passes a job queue entry and the sequencer's job register; its
//   first beat then sits in a result queue entry, on the outputs; a request is a load
//   step, the sync symbol and one symbol per bit; an error item is a load step and
//   one beat; the sequencer emits one beat per cycle while the result queue has room;
//   a two-entry job queue lets the next request be taken while a run is in progress
// reset: synchronous active-low rst_n empties both queues and idles the sequencer
// ----------------------------------------------------------------------------
// pulse_width_code_encoder
// on-off-keyed remote code encoder: request in, signed pulse pairs out
// ----------------------------------------------------------------------------
module pulse_width_code_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [pwce_pkg::IdxW-1:0]        in_protocol_index,
  input  logic [pwce_pkg::BitsW-1:0]       in_bit_count,
  input  logic [pwce_pkg::CodeW-1:0]       in_code_value,
  input  logic [pwce_pkg::RoomW-1:0]       in_room,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic signed [pwce_pkg::DurW-1:0] out_first_pulse_us,
  output logic signed [pwce_pkg::DurW-1:0] out_second_pulse_us,
  output logic                             out_last_symbol,
  output logic [1:0]                       out_error_code
);
  import pwce_pkg::*;

  job_t      jq_din, jq_dout;
  logic      jq_push, jq_pop;
  q_status_t jq_status;

  pwce_front u_front (
    .in_push           (in_push),
    .in_full           (in_full),
    .in_protocol_index (in_protocol_index),
    .in_bit_count      (in_bit_count),
    .in_code_value     (in_code_value),
    .in_room           (in_room),
    .jq_status         (jq_status),
    .jq_push           (jq_push),
    .jq_din            (jq_din)
  );

  pwce_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (jq_push),
    .din    (jq_din),
    .pop    (jq_pop),
    .dout   (jq_dout),
    .status (jq_status)
  );

  pwce_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .jq_dout             (jq_dout),
    .jq_status           (jq_status),
    .jq_pop              (jq_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_first_pulse_us  (out_first_pulse_us),
    .out_second_pulse_us (out_second_pulse_us),
    .out_last_symbol     (out_last_symbol),
    .out_error_code      (out_error_code)
  );

endmodule
